FILE: hw/rtl/bpfb_pkg.sv
// Shared constants and types for the bad page frame blacklist unit.
package bpfb_pkg;

    localparam int CAPACITY   = 32;
    localparam int ADDR_W     = 52;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
    localparam int COUNT_W    = 6;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Search token that travels down the chain of cells.
    typedef struct packed {
        logic              vld;
        logic              hit;
        logic [PAGE_W-1:0] page;
    } t_token;

    // Write request broadcast to all cells; only the addressed cell takes it.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [PAGE_W-1:0] page;
    } t_write;

endpackage

FILE: hw/rtl/bpfb_cell.sv
// One cell of the blacklist chain: holds one page entry and checks the passing token.
module bpfb_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [bpfb_pkg::IDX_W-1:0] i_index,
    input  logic [bpfb_pkg::CNT_W-1:0] i_count,
    input  bpfb_pkg::t_token       i_tok,
    input  bpfb_pkg::t_write       i_wr,
    output bpfb_pkg::t_token       o_tok
);

    logic [bpfb_pkg::PAGE_W-1:0] r_entry;
    bpfb_pkg::t_token            r_tok;
    bpfb_pkg::t_token            n_tok;
    logic                        in_use;

    // Only entries below the fill count hold a listed page.
    assign in_use = bpfb_pkg::CNT_W'(i_index) < i_count;

    always_comb begin
        n_tok     = i_tok;
        n_tok.hit = i_tok.hit | (in_use && (r_entry == i_tok.page));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= n_tok.vld;
        end
        r_tok.hit  <= n_tok.hit;
        r_tok.page <= n_tok.page;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_index)) begin
            r_entry <= i_wr.page;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: hw/rtl/bad_page_frame_blacklist_unit.sv
// Top level of the bad page frame blacklist unit: control, fill count and cell chain.
//
// Requests arrive on the input channel (i_valid / o_ready) with an operation
// (lookup or insert) and a 52-bit physical byte address; the low 12 bits are
// dropped to form the page number. Each transaction yields exactly one result
// on the output channel (o_valid / i_ready): answer, was_present, full_res and
// the entry count after the request.
// The search token enters the first cell at the accepting edge and moves one
// cell per cycle through a chain of CAPACITY cells, each comparing its entry.
// When the token leaves the last cell its result is registered; that result is
// loaded into the output register, and only after that is the next request taken.
// An insert of a new page is written into its cell, if the list has room, as the result is loaded.
// Reset empties the list by clearing the fill count; entries are not cleared.
// The output register lets the next request enter while a result waits; if
// the receiver stalls, the following scan finishes and holds its result until
// the output register is free.
module bad_page_frame_blacklist_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_op,
    input  logic [bpfb_pkg::ADDR_W-1:0] i_phys_addr,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_answer,
    output logic                        o_was_present,
    output logic                        o_full_res,
    output logic [bpfb_pkg::COUNT_W-1:0] o_entry_count
);

    bpfb_pkg::t_state r_state;
    bpfb_pkg::t_state n_state;

    logic                        r_op;
    logic                        r_hit;
    logic [bpfb_pkg::PAGE_W-1:0] r_page;
    logic [bpfb_pkg::CNT_W-1:0]  r_used;
    logic [bpfb_pkg::CNT_W-1:0]  n_used;

    logic                         r_out_vld;
    logic                         r_answer;
    logic                         r_was_present;
    logic                         r_full_res;
    logic [bpfb_pkg::COUNT_W-1:0] r_entry_count;

    logic                         accept;
    logic                         load;
    logic                         room;
    logic                         add;
    logic                         res_answer;
    logic                         res_full;

    bpfb_pkg::t_token tok [bpfb_pkg::CAPACITY+1];
    bpfb_pkg::t_write wr;

    assign accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            bpfb_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = bpfb_pkg::ST_SCAN;
                end
            end
            bpfb_pkg::ST_SCAN: begin
                if (tok[bpfb_pkg::CAPACITY].vld) begin
                    n_state = bpfb_pkg::ST_FINISH;
                end
            end
            bpfb_pkg::ST_FINISH: begin
                if (!r_out_vld || i_ready) begin
                    n_state = bpfb_pkg::ST_IDLE;
                end
            end
            default: n_state = bpfb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == bpfb_pkg::ST_IDLE);
        load    = (r_state == bpfb_pkg::ST_FINISH) && (!r_out_vld || i_ready);
    end

    // Result of the finished scan.
    assign room       = r_used != bpfb_pkg::CNT_W'(bpfb_pkg::CAPACITY);
    assign add        = (r_op == bpfb_pkg::OP_INSERT) && !r_hit && room;
    assign res_answer = r_hit | add;
    assign res_full   = (r_op == bpfb_pkg::OP_INSERT) && !r_hit && !room;
    assign n_used     = add ? r_used + 1'b1 : r_used;

    assign wr.en   = load && add;
    assign wr.idx  = bpfb_pkg::IDX_W'(r_used);
    assign wr.page = r_page;

    assign tok[0].vld  = accept;
    assign tok[0].hit  = 1'b0;
    assign tok[0].page = i_phys_addr[bpfb_pkg::ADDR_W-1:bpfb_pkg::PAGE_SHIFT];

    for (genvar g = 0; g < bpfb_pkg::CAPACITY; g++) begin : g_cell
        bpfb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (bpfb_pkg::IDX_W'(g)),
            .i_count (r_used),
            .i_tok   (tok[g]),
            .i_wr    (wr),
            .o_tok   (tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bpfb_pkg::ST_IDLE;
            r_used    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_used    <= n_used;
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_op;
        end
        if (r_state == bpfb_pkg::ST_SCAN && tok[bpfb_pkg::CAPACITY].vld) begin
            r_hit  <= tok[bpfb_pkg::CAPACITY].hit;
            r_page <= tok[bpfb_pkg::CAPACITY].page;
        end
        if (load) begin
            r_answer      <= res_answer;
            r_was_present <= r_hit;
            r_full_res    <= res_full;
            r_entry_count <= bpfb_pkg::COUNT_W'(n_used);
        end
    end

    assign o_valid       = r_out_vld;
    assign o_answer      = r_answer;
    assign o_was_present = r_was_present;
    assign o_full_res    = r_full_res;
    assign o_entry_count = r_entry_count;

endmodule

FILE: hw/rtl/bpfb_checker.sv
// Port-level checks for the bad page frame blacklist unit, bound to the top level.
module bpfb_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic                         o_answer,
    input logic                         o_was_present,
    input logic                         o_full_res,
    input logic [bpfb_pkg::COUNT_W-1:0] o_entry_count
);

    // Only one transaction is in the chain at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request accepted while a scan is running");

    a_full_only_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_full_res |-> !o_answer && !o_was_present)
        else $error("full result with answer or was_present set");

    a_present_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_was_present |-> o_answer && !o_full_res)
        else $error("listed page not answered");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_count <= bpfb_pkg::COUNT_W'(bpfb_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_entry_count) && $stable(o_answer))
        else $error("stalled result changed");

endmodule

bind bad_page_frame_blacklist_unit bpfb_checker u_bpfb_checker (.*);
